>>> rtl/zlbm_pkg.sv
// ============================================================================
// Zoned log bucket mapper package
// Shared widths, limits, operation and status codes and register indexes.
// ============================================================================
package zlbm_pkg;

    localparam int ADDR_W   = 48;   // byte address width
    localparam int SLOT_W   = 26;   // global slot index width
    localparam int BPU_W    = 17;   // slots per zone, up to 65536
    localparam int UNIT_W   = 10;   // zone pointer width
    localparam int NUNIT_W  = 11;   // zone count width
    localparam int BID_W    = 16;   // bucket id width
    localparam int REGIDX_W = 3;
    localparam int CFG_W    = 48;

    localparam int MAX_BUCKETS        = 65536;
    localparam int MAX_UNITS          = 1024;
    localparam int MAX_SLOTS_PER_UNIT = 65536;

    // Operation kinds carried on the input tuser.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;
    localparam logic [1:0] KIND_SCAN  = 2'd3;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_UNMAPPED = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // Configuration register indexes.
    localparam logic [REGIDX_W-1:0] REG_NUM_UNITS  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_BPU        = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_BUCKET_B   = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_ZONE_B     = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_BASE       = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_THRESHOLD  = 3'd5;
    localparam logic [REGIDX_W-1:0] REG_IN_USE     = 3'd6;

    // Map entry: valid bit on top of the slot index.
    localparam int MAP_W = SLOT_W + 1;

endpackage

>>> rtl/zoned_log_bucket_mapper.sv
// ============================================================================
// Zoned log bucket mapper
// Maps logical buckets onto a ring of flash zones written as a log.
// ============================================================================
// Usage: each input transaction carries an operation kind on s_axis_tuser
// (write, read, erase, scan) and a bucket id on s_axis_tdata. Every input
// transaction produces exactly one output transaction with a status on
// m_axis_tuser and the location, zone base, zone open/close flags, found
// bucket and should-clean flag on m_axis_tdata. Registers are written
// through cfg_we/cfg_index/cfg_data while the block is idle.
// The block works on one operation at a time; s_axis_tready is high only
// when it is idle. A shared 26x21 multiplier builds every address as a sum
// of partial products, and a one-bit-per-cycle divider splits a slot index
// into zone and offset. Reads and writes both pass through the divider's
// 26 iterations; a scan walks the map memory one entry per cycle. After
// reset the valid bits of the map memory are swept clear, one entry a
// cycle, before the first input is accepted. A result is held in the
// output register until the receiver takes it; the next input is accepted
// only after that.
// ============================================================================
module zoned_log_bucket_mapper (
    input  logic          clk,
    input  logic          rst_n,
    // Input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // [15:0] bucket_id
    input  logic [1:0]    s_axis_tuser,   // [1:0] kind
    // Output stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,   // [47:0] location, [95:48] zone_base,
                                          // [96] zone_opened, [97] zone_closed,
                                          // [113:98] found_bucket,
                                          // [114] should_clean, rest zero
    output logic [1:0]    m_axis_tuser,   // [1:0] status
    // Configuration write port
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [47:0]   cfg_data
);

    localparam int ADDR_W  = zlbm_pkg::ADDR_W;
    localparam int SLOT_W  = zlbm_pkg::SLOT_W;
    localparam int BPU_W   = zlbm_pkg::BPU_W;
    localparam int UNIT_W  = zlbm_pkg::UNIT_W;
    localparam int NUNIT_W = zlbm_pkg::NUNIT_W;
    localparam int BID_W   = zlbm_pkg::BID_W;
    localparam int MAP_W   = zlbm_pkg::MAP_W;
    localparam int MUL_AW  = SLOT_W;
    localparam int MUL_BW  = 21;
    localparam int PROD_W  = MUL_AW + MUL_BW;

    // Sequencer states.
    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_WM   = 5'd2;
    localparam logic [4:0] ST_WS   = 5'd3;
    localparam logic [4:0] ST_BL   = 5'd4;
    localparam logic [4:0] ST_BH   = 5'd5;
    localparam logic [4:0] ST_BF   = 5'd6;
    localparam logic [4:0] ST_RW   = 5'd7;
    localparam logic [4:0] ST_DS   = 5'd8;
    localparam logic [4:0] ST_DIV  = 5'd9;
    localparam logic [4:0] ST_LO   = 5'd10;
    localparam logic [4:0] ST_LZL  = 5'd11;
    localparam logic [4:0] ST_LZH  = 5'd12;
    localparam logic [4:0] ST_LF   = 5'd13;
    localparam logic [4:0] ST_SI   = 5'd14;
    localparam logic [4:0] ST_SH   = 5'd15;
    localparam logic [4:0] ST_SCK  = 5'd16;
    localparam logic [4:0] ST_CLN  = 5'd17;
    localparam logic [4:0] ST_CLF  = 5'd18;
    localparam logic [4:0] ST_OUT  = 5'd19;

    // Configuration registers.
    logic [NUNIT_W-1:0] nunits_reg;
    logic [BPU_W-1:0]   bpu_reg;
    logic [20:0]        bbytes_reg;
    logic [36:0]        zbytes_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [15:0]        thr_reg;
    logic [BPU_W-1:0]   inuse_reg;

    logic [4:0]         state_reg, state_next;
    logic [BID_W-1:0]   clr_reg, clr_next;
    logic [UNIT_W-1:0]  wu_reg, wu_next;
    logic [UNIT_W-1:0]  eu_reg, eu_next;
    logic [BID_W-1:0]   ws_reg, ws_next;
    logic [1:0]         kind_reg, kind_next;
    logic [BID_W-1:0]   id_reg, id_next;
    logic [UNIT_W-1:0]  zu_reg, zu_next;
    logic [SLOT_W-1:0]  s_reg, s_next;
    logic [BID_W-1:0]   scan_reg, scan_next;
    logic [SLOT_W-1:0]  lo_reg, lo_next;
    logic [SLOT_W:0]    hi_reg, hi_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [ADDR_W-1:0]  acc_reg, acc_next;
    logic               sh_reg, sh_next;

    // Result registers.
    logic [1:0]         status_reg, status_next;
    logic [ADDR_W-1:0]  loc_reg, loc_next;
    logic [ADDR_W-1:0]  zbase_reg, zbase_next;
    logic               opened_reg, opened_next;
    logic               closed_reg, closed_next;
    logic [BID_W-1:0]   found_reg, found_next;
    logic               clean_reg, clean_next;

    logic [NUNIT_W-1:0] eff_n;
    logic [BPU_W-1:0]   eff_b;
    logic [BPU_W-1:0]   lim;
    logic [NUNIT_W-1:0] wu_inc, eu_inc;
    logic [UNIT_W-1:0]  wu_nx, eu_nx;
    logic [BPU_W-1:0]   ws_inc;
    logic [NUNIT_W-1:0] free_z;
    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic [ADDR_W-1:0]  addend;
    logic [ADDR_W-1:0]  acc_sum;
    logic [SLOT_W-1:0]  s_calc;
    logic               w_open, w_close;
    logic [BPU_W-1:0]   scan_inc;
    logic               scan_hit;

    logic               ram_we;
    logic [BID_W-1:0]   ram_waddr, ram_raddr;
    logic [MAP_W-1:0]   ram_wdata, ram_rdata;

    logic               div_start, div_done;
    logic [SLOT_W-1:0]  div_q;
    logic [BPU_W-1:0]   div_r;

    logic               in_acc;

    // Saturated register views.
    always_comb
    begin
        if (nunits_reg == '0)
            eff_n = NUNIT_W'(1);
        else if (nunits_reg > NUNIT_W'(zlbm_pkg::MAX_UNITS))
            eff_n = NUNIT_W'(zlbm_pkg::MAX_UNITS);
        else
            eff_n = nunits_reg;

        if (bpu_reg == '0)
            eff_b = BPU_W'(1);
        else if (bpu_reg > BPU_W'(zlbm_pkg::MAX_SLOTS_PER_UNIT))
            eff_b = BPU_W'(zlbm_pkg::MAX_SLOTS_PER_UNIT);
        else
            eff_b = bpu_reg;

        if (inuse_reg > BPU_W'(zlbm_pkg::MAX_BUCKETS))
            lim = BPU_W'(zlbm_pkg::MAX_BUCKETS);
        else
            lim = inuse_reg;
    end

    // Pointer advance wraps to zone 0 from the last zone, or from any zone beyond it.
    assign wu_inc = {1'b0, wu_reg} + NUNIT_W'(1);
    assign eu_inc = {1'b0, eu_reg} + NUNIT_W'(1);
    assign wu_nx  = (wu_inc >= eff_n) ? '0 : wu_inc[UNIT_W-1:0];
    assign eu_nx  = (eu_inc >= eff_n) ? '0 : eu_inc[UNIT_W-1:0];
    assign ws_inc = {1'b0, ws_reg} + BPU_W'(1);

    assign free_z = (eu_reg >= wu_reg)
                  ? ({1'b0, eu_reg} - {1'b0, wu_reg})
                  : ({1'b0, eu_reg} + eff_n - {1'b0, wu_reg});

    assign s_calc  = prod_reg[SLOT_W-1:0] + SLOT_W'(ws_reg);
    assign w_open  = (ws_reg == '0);
    assign w_close = (ws_inc >= eff_b);

    assign scan_inc = {1'b0, scan_reg} + BPU_W'(1);
    assign scan_hit = ram_rdata[MAP_W-1]
                   && (ram_rdata[SLOT_W-1:0] >= lo_reg)
                   && ({1'b0, ram_rdata[SLOT_W-1:0]} < hi_reg);

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        sh_next = 1'b0;
        unique case (state_reg)
            ST_WM, ST_SI:
            begin
                mul_a = MUL_AW'(state_reg == ST_WM ? wu_reg : eu_reg);
                mul_b = MUL_BW'(eff_b);
            end
            ST_BL:
            begin
                mul_a = MUL_AW'(zu_reg);
                mul_b = zbytes_reg[20:0];
            end
            ST_BH:
            begin
                mul_a   = MUL_AW'(zu_reg);
                mul_b   = MUL_BW'(zbytes_reg[36:21]);
                sh_next = 1'b1;
            end
            ST_LO:
            begin
                mul_a = MUL_AW'(div_r);
                mul_b = bbytes_reg;
            end
            ST_LZL:
            begin
                mul_a = div_q;
                mul_b = zbytes_reg[20:0];
            end
            ST_LZH:
            begin
                mul_a   = div_q;
                mul_b   = MUL_BW'(zbytes_reg[36:21]);
                sh_next = 1'b1;
            end
            ST_CLN:
            begin
                mul_a = MUL_AW'(eff_n);
                mul_b = MUL_BW'(thr_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The high half of the zone stride lands 21 bits up; sums wrap at 2^48.
    assign addend  = sh_reg ? ADDR_W'({prod_reg, 21'b0}) : ADDR_W'(prod_reg);
    assign acc_sum = acc_reg + addend;
    assign acc_next = (state_reg == ST_BL || state_reg == ST_LO) ? base_reg : acc_sum;

    // Map memory ports.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_WS)
        begin
            ram_we    = 1'b1;
            ram_waddr = id_reg;
            ram_wdata = {1'b1, s_calc};
        end

        if (state_reg == ST_IDLE)
            ram_raddr = s_axis_tdata;
        else if (state_reg == ST_SCK)
            ram_raddr = scan_inc[BID_W-1:0];
        else
            ram_raddr = scan_reg;
    end

    assign div_start = (state_reg == ST_DS);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        wu_next     = wu_reg;
        eu_next     = eu_reg;
        ws_next     = ws_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        zu_next     = zu_reg;
        s_next      = s_reg;
        scan_next   = scan_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        status_next = status_reg;
        loc_next    = loc_reg;
        zbase_next  = zbase_reg;
        opened_next = opened_reg;
        closed_next = closed_reg;
        found_next  = found_reg;
        clean_next  = clean_reg;

        unique case (state_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next   = s_axis_tuser;
                    id_next     = s_axis_tdata;
                    scan_next   = s_axis_tdata;
                    status_next = zlbm_pkg::STAT_OK;
                    loc_next    = '0;
                    zbase_next  = '0;
                    opened_next = 1'b0;
                    closed_next = 1'b0;
                    found_next  = '0;
                    unique case (s_axis_tuser)
                        zlbm_pkg::KIND_WRITE:
                        begin
                            if (wu_reg == eu_reg)
                            begin
                                status_next = zlbm_pkg::STAT_FULL;
                                state_next  = ST_CLN;
                            end
                            else
                            begin
                                state_next = ST_WM;
                            end
                        end
                        zlbm_pkg::KIND_READ:
                        begin
                            state_next = ST_RW;
                        end
                        zlbm_pkg::KIND_ERASE:
                        begin
                            zu_next    = eu_reg;
                            eu_next    = eu_nx;
                            state_next = ST_BL;
                        end
                        zlbm_pkg::KIND_SCAN:
                        begin
                            if ({1'b0, s_axis_tdata} >= lim)
                            begin
                                status_next = zlbm_pkg::STAT_NOTFOUND;
                                state_next  = ST_CLN;
                            end
                            else
                            begin
                                state_next = ST_SI;
                            end
                        end
                        default:
                        begin
                            state_next = ST_CLN;
                        end
                    endcase
                end
            end
            ST_WM:
            begin
                state_next = ST_WS;
            end
            ST_WS:
            begin
                // Slot is taken; advance the write pointer right away.
                s_next      = s_calc;
                zu_next     = wu_reg;
                opened_next = w_open;
                closed_next = w_close;
                if (w_close)
                begin
                    wu_next = wu_nx;
                    ws_next = '0;
                end
                else
                begin
                    ws_next = ws_inc[BID_W-1:0];
                end
                state_next = (w_open || w_close) ? ST_BL : ST_DS;
            end
            ST_BL:
            begin
                state_next = ST_BH;
            end
            ST_BH:
            begin
                state_next = ST_BF;
            end
            ST_BF:
            begin
                zbase_next = acc_sum;
                state_next = (kind_reg == zlbm_pkg::KIND_WRITE) ? ST_DS : ST_CLN;
            end
            ST_RW:
            begin
                if (ram_rdata[MAP_W-1])
                begin
                    s_next     = ram_rdata[SLOT_W-1:0];
                    state_next = ST_DS;
                end
                else
                begin
                    status_next = zlbm_pkg::STAT_UNMAPPED;
                    state_next  = ST_CLN;
                end
            end
            ST_DS:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_LO;
            end
            ST_LO:
            begin
                state_next = ST_LZL;
            end
            ST_LZL:
            begin
                state_next = ST_LZH;
            end
            ST_LZH:
            begin
                state_next = ST_LF;
            end
            ST_LF:
            begin
                loc_next   = acc_sum;
                state_next = ST_CLN;
            end
            ST_SI:
            begin
                state_next = ST_SH;
            end
            ST_SH:
            begin
                // Erase zone spans slots [lo, lo + slots per zone).
                lo_next    = prod_reg[SLOT_W-1:0];
                hi_next    = {1'b0, prod_reg[SLOT_W-1:0]} + (SLOT_W + 1)'(eff_b);
                state_next = ST_SCK;
            end
            ST_SCK:
            begin
                if (scan_hit)
                begin
                    status_next = zlbm_pkg::STAT_OK;
                    found_next  = scan_reg;
                    state_next  = ST_CLN;
                end
                else if (scan_inc >= lim)
                begin
                    status_next = zlbm_pkg::STAT_NOTFOUND;
                    state_next  = ST_CLN;
                end
                else
                begin
                    scan_next = scan_inc[BID_W-1:0];
                end
            end
            ST_CLN:
            begin
                state_next = ST_CLF;
            end
            ST_CLF:
            begin
                clean_next = ({free_z, 16'b0} <= prod_reg[NUNIT_W+15:0]);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            clr_reg    <= '0;
            wu_reg     <= '0;
            ws_reg     <= '0;
            eu_reg     <= UNIT_W'(15);
            nunits_reg <= NUNIT_W'(16);
            bpu_reg    <= BPU_W'(64);
            bbytes_reg <= 21'd4096;
            zbytes_reg <= 37'd262144;
            base_reg   <= '0;
            thr_reg    <= 16'd6554;
            inuse_reg  <= BPU_W'(65536);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            wu_reg    <= wu_next;
            ws_reg    <= ws_next;
            eu_reg    <= eu_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    zlbm_pkg::REG_NUM_UNITS: nunits_reg <= cfg_data[NUNIT_W-1:0];
                    zlbm_pkg::REG_BPU:       bpu_reg    <= cfg_data[BPU_W-1:0];
                    zlbm_pkg::REG_BUCKET_B:  bbytes_reg <= cfg_data[20:0];
                    zlbm_pkg::REG_ZONE_B:    zbytes_reg <= cfg_data[36:0];
                    zlbm_pkg::REG_BASE:      base_reg   <= cfg_data;
                    zlbm_pkg::REG_THRESHOLD: thr_reg    <= cfg_data[15:0];
                    zlbm_pkg::REG_IN_USE:    inuse_reg  <= cfg_data[BPU_W-1:0];
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        id_reg     <= id_next;
        zu_reg     <= zu_next;
        s_reg      <= s_next;
        scan_reg   <= scan_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        prod_reg   <= mul_a * mul_b;
        acc_reg    <= acc_next;
        sh_reg     <= sh_next;
        status_reg <= status_next;
        loc_reg    <= loc_next;
        zbase_reg  <= zbase_next;
        opened_reg <= opened_next;
        closed_reg <= closed_next;
        found_reg  <= found_next;
        clean_reg  <= clean_next;
    end

    zlbm_ram #(
        .WIDTH (MAP_W),
        .DEPTH (zlbm_pkg::MAX_BUCKETS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    zlbm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_reg),
        .divisor   (eff_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {5'b0, clean_reg, found_reg, closed_reg, opened_reg,
                            zbase_reg, loc_reg};

`ifndef ASSERT_OFF
    // The divider only reports completion while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside of divide wait");

    // Map writes outside the clearing sweep always set the valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLR) |-> ram_wdata[MAP_W-1])
        else $error("map write without valid bit");

    // A write accepted with room in the log never reports full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser == zlbm_pkg::KIND_WRITE && wu_reg != eu_reg)
        |=> (status_next != zlbm_pkg::STAT_FULL))
        else $error("full status with free zones");

    // No input is taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
`endif

endmodule

>>> rtl/zlbm_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module zlbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/zlbm_div.sv
// ============================================================================
// Slot index divider
// Restoring divider, one quotient bit per cycle, splits a slot index into
// zone number and offset within the zone.
// ============================================================================
module zlbm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [zlbm_pkg::SLOT_W-1:0] dividend,
    input  logic [zlbm_pkg::BPU_W-1:0]  divisor,
    output logic                        done,
    output logic [zlbm_pkg::SLOT_W-1:0] quotient,
    output logic [zlbm_pkg::BPU_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(zlbm_pkg::SLOT_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [zlbm_pkg::SLOT_W-1:0] q_reg, q_next;
    logic [zlbm_pkg::BPU_W-1:0]  r_reg, r_next;
    logic [zlbm_pkg::BPU_W:0]    trial;
    logic [zlbm_pkg::BPU_W:0]    diff;
    logic                        ge;

    assign trial = {r_reg, q_reg[zlbm_pkg::SLOT_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(zlbm_pkg::SLOT_W - 1);
            q_next    = dividend;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next = ge ? diff[zlbm_pkg::BPU_W-1:0] : trial[zlbm_pkg::BPU_W-1:0];
            q_next = {q_reg[zlbm_pkg::SLOT_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> tb/sv/tb_zoned_log_bucket_mapper.sv
// ============================================================================
// Zoned log bucket mapper testbench
// Drives write, read, erase and scan transactions through the stream ports.
// A built-in model of the zone ring and bucket map predicts every result, and
// each output transaction is checked field by field. The run starts with a
// table of directed rows, then walks several register settings (extremes and
// out-of-range values among them) with random traffic, random idling on both
// sides, one long receiver stall and one sender pause.
// ============================================================================
module tb_zoned_log_bucket_mapper;

    import zlbm_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  NUM_PHASES  = 9;
    localparam int  SETTLE      = 100;
    localparam longint unsigned AMASK = 64'hFFFF_FFFF_FFFF;

    // One result transaction, unpacked.
    typedef struct {
        logic [1:0]  status;
        logic [47:0] location;
        logic [47:0] zone_base;
        logic        opened;
        logic        closed;
        logic [15:0] found;
        logic        clean;
    } mapping_t;

    // One directed row. Where known is set, status, location and zone base
    // are typed in here instead of taken from the predictor.
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] id;
        bit          known;
        logic [1:0]  status;
        logic [47:0] location;
        logic [47:0] zone_base;
    } row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [15:0]   s_axis_tdata = '0;   // [15:0] bucket_id
    logic [1:0]    s_axis_tuser = '0;   // [1:0] kind
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [119:0]  m_axis_tdata;        // [47:0] location, [95:48] zone_base,
                                        // [96] opened, [97] closed,
                                        // [113:98] found_bucket, [114] should_clean
    logic [1:0]    m_axis_tuser;        // [1:0] status
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [47:0]   cfg_data = '0;

    zoned_log_bucket_mapper DUT (.*);

    // Model state: registers, map table and ring pointers.
    longint unsigned zone_cnt, slots_per_zone, slot_bytes, zone_stride, log_base;
    longint unsigned clean_thr, scan_bound;
    logic [SLOT_W-1:0] bucket_slot [MAX_BUCKETS];
    bit                bucket_mapped [MAX_BUCKETS];
    longint unsigned wr_zone, wr_slot, er_zone;

    mapping_t pending_results [$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       receiver_hold = 0;     // long stall request for the receiver
    bit       idle_on = 1'b1;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("zoned_log_bucket_mapper regression: fail");
            $finish;
        end
    end

    function automatic longint unsigned zones_eff();
        if (zone_cnt < 1) return 1;
        if (zone_cnt > MAX_UNITS) return MAX_UNITS;
        return zone_cnt;
    endfunction

    function automatic longint unsigned slots_eff();
        if (slots_per_zone < 1) return 1;
        if (slots_per_zone > MAX_SLOTS_PER_UNIT) return MAX_SLOTS_PER_UNIT;
        return slots_per_zone;
    endfunction

    function automatic longint unsigned zone_addr(longint unsigned u);
        return (log_base + u * zone_stride) & AMASK;
    endfunction

    function automatic longint unsigned slot_byte_addr(longint unsigned s);
        longint unsigned b;
        b = slots_eff();
        return (log_base + (s % b) * slot_bytes + (s / b) * zone_stride) & AMASK;
    endfunction

    function automatic longint unsigned advance_zone(longint unsigned u);
        return (u + 1 >= zones_eff()) ? 0 : u + 1;
    endfunction

    function automatic longint unsigned scan_limit();
        return (scan_bound > MAX_BUCKETS) ? MAX_BUCKETS : scan_bound;
    endfunction

    task automatic reset_model();
        zone_cnt = 16;
        slots_per_zone = 64;
        slot_bytes = 4096;
        zone_stride = 262144;
        log_base = 0;
        clean_thr = 6554;
        scan_bound = 65536;
        foreach (bucket_mapped[i]) bucket_mapped[i] = 1'b0;
        wr_zone = 0;
        wr_slot = 0;
        er_zone = zones_eff() - 1;
    endtask

    // Applies one operation to the model and returns the result it causes.
    function automatic mapping_t map_operation(logic [1:0] kind, logic [15:0] id);
        mapping_t r;
        longint unsigned b, s, n, free_zones, lim;
        b = slots_eff();
        r = '{status: STAT_OK, location: '0, zone_base: '0, opened: 1'b0,
              closed: 1'b0, found: '0, clean: 1'b0};
        case (kind)
            KIND_WRITE:
            begin
                if (wr_zone == er_zone)
                    r.status = STAT_FULL;
                else
                begin
                    s = wr_zone * b + wr_slot;
                    if (wr_slot == 0)
                    begin
                        r.opened = 1'b1;
                        r.zone_base = zone_addr(wr_zone);
                    end
                    bucket_slot[id] = s[SLOT_W-1:0];
                    bucket_mapped[id] = 1'b1;
                    r.location = slot_byte_addr(s);
                    wr_slot++;
                    if (wr_slot >= b)
                    begin
                        r.closed = 1'b1;
                        r.zone_base = zone_addr(wr_zone);
                        wr_zone = advance_zone(wr_zone);
                        wr_slot = 0;
                    end
                end
            end
            KIND_READ:
            begin
                if (bucket_mapped[id])
                    r.location = slot_byte_addr(bucket_slot[id]);
                else
                    r.status = STAT_UNMAPPED;
            end
            KIND_ERASE:
            begin
                r.zone_base = zone_addr(er_zone);
                er_zone = advance_zone(er_zone);
            end
            default:
            begin
                lim = scan_limit();
                r.status = STAT_NOTFOUND;
                for (longint unsigned i = id; i < lim; i++)
                begin
                    if (bucket_mapped[i] && (bucket_slot[i] / b) == er_zone)
                    begin
                        r.status = STAT_OK;
                        r.found = i[15:0];
                        break;
                    end
                end
            end
        endcase
        // The should-clean flag reflects the ring after the operation.
        n = zones_eff();
        free_zones = (er_zone >= wr_zone) ? er_zone - wr_zone : er_zone + n - wr_zone;
        r.clean = (free_zones * 65536 <= clean_thr * n);
        return r;
    endfunction

    task automatic write_register(logic [2:0] idx, longint unsigned value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[47:0];
        case (idx)
            REG_NUM_UNITS: zone_cnt = value & 64'h7FF;
            REG_BPU:       slots_per_zone = value & 64'h1FFFF;
            REG_BUCKET_B:  slot_bytes = value & 64'h1FFFFF;
            REG_ZONE_B:    zone_stride = value & 64'h1F_FFFF_FFFF;
            REG_BASE:      log_base = value & AMASK;
            REG_THRESHOLD: clean_thr = value & 64'hFFFF;
            default:       scan_bound = value & 64'h1FFFF;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offers one input transaction, waits for it to be taken, then records
    // the expected result. Returns positioned just after a falling edge.
    task automatic offer_operation(logic [1:0] kind, logic [15:0] id, bit known,
                                   logic [1:0] st, logic [47:0] loc, logic [47:0] zb);
        int gap;
        mapping_t r;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = kind;
        s_axis_tdata = id;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = map_operation(kind, id);
        if (known)
        begin
            r.status = st;
            r.location = loc;
            r.zone_base = zb;
        end
        pending_results.push_back(r);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Register settings per phase: small rings and tiny zones make the log
    // wrap, fill and close often; a few phases hold the extremes.
    task automatic load_phase(int p);
        longint unsigned v [7];
        v[0] = $urandom_range(2, 8);
        v[1] = $urandom_range(1, 8);
        v[2] = $urandom_range(1, 1048576);
        v[3] = {$urandom, $urandom} & 64'h1F_FFFF_FFFF;
        v[4] = {$urandom, $urandom} & AMASK;
        v[5] = $urandom_range(0, 65535);
        v[6] = $urandom_range(1, 1024);
        case (p)
            1:
            begin
                // One slot per zone, top address, threshold maximum.
                v = '{4, 1, 1, 1, AMASK, 65535, 300};
            end
            2:
            begin
                // Zero zone and slot counts saturate up to one.
                v = '{0, 0, 64'h1FFFFF, 64'h1F_FFFF_FFFF, v[4], 0, 0};
            end
            3:
            begin
                // Counts beyond the limits saturate down.
                v = '{2047, 131071, 1048576, 64'h10_0000_0000, 64'h1234_5678_9ABC,
                      32768, 131071};
            end
            4:
            begin
                v = '{1024, 65536, 4096, 262144, 0, 6554, 65536};
            end
            5:
            begin
                v[0] = 2;
            end
            default: ;
        endcase
        for (int i = 0; i < 7; i++)
            write_register(i[2:0], v[i]);
    endtask

    function automatic logic [15:0] pick_bucket(bit scan);
        longint unsigned lim, lo;
        lim = scan_limit();
        lo = (lim > 512) ? lim - 512 : 0;
        if (!scan && $urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 65535));
        if (scan && $urandom_range(0, 9) == 0)
            return 16'($urandom_range(lo, 65535));
        return 16'($urandom_range(lo, lo + 511));
    endfunction

    // Receiver: draws a stall before each result, and honors a long hold.
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (receiver_hold > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (receiver_hold) @(negedge clk);
                receiver_hold = 0;
            end
            w = idle_on ? $urandom_range(0, 4) : 0;
            if (w > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (w) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        mapping_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, status %0d", $realtime, m_axis_tuser);
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tuser !== e.status)
                begin
                    error_count++;
                    $display("%0t: status exp %0d got %0d", $realtime, e.status,
                             m_axis_tuser);
                end
                if (m_axis_tdata[47:0] !== e.location)
                begin
                    error_count++;
                    $display("%0t: location exp %h got %h", $realtime, e.location,
                             m_axis_tdata[47:0]);
                end
                if (m_axis_tdata[95:48] !== e.zone_base)
                begin
                    error_count++;
                    $display("%0t: zone_base exp %h got %h", $realtime, e.zone_base,
                             m_axis_tdata[95:48]);
                end
                if (m_axis_tdata[96] !== e.opened || m_axis_tdata[97] !== e.closed)
                begin
                    error_count++;
                    $display("%0t: opened/closed exp %b%b got %b%b", $realtime,
                             e.opened, e.closed, m_axis_tdata[96], m_axis_tdata[97]);
                end
                if (m_axis_tdata[113:98] !== e.found)
                begin
                    error_count++;
                    $display("%0t: found_bucket exp %0d got %0d", $realtime, e.found,
                             m_axis_tdata[113:98]);
                end
                if (m_axis_tdata[114] !== e.clean)
                begin
                    error_count++;
                    $display("%0t: should_clean exp %b got %b", $realtime, e.clean,
                             m_axis_tdata[114]);
                end
            end
        end
    end

    // Directed rows run with the reset register values: ring of 16 zones,
    // 64 slots of 4096 bytes, zone stride 262144, base 0.
    row_t directed [12] = '{
        '{KIND_READ,  16'd0,     1, STAT_UNMAPPED, 48'd0,    48'd0},
        '{KIND_WRITE, 16'd0,     1, STAT_OK,       48'd0,    48'd0},
        '{KIND_WRITE, 16'hFFFF,  1, STAT_OK,       48'd4096, 48'd0},
        '{KIND_READ,  16'hFFFF,  1, STAT_OK,       48'd4096, 48'd0},
        '{KIND_READ,  16'd0,     1, STAT_OK,       48'd0,    48'd0},
        // Erase of the last zone wraps the erase pointer onto the write zone.
        '{KIND_ERASE, 16'd0,     1, STAT_OK,       48'd0,    48'd3932160},
        '{KIND_SCAN,  16'd0,     0, STAT_OK,       48'd0,    48'd0},
        '{KIND_SCAN,  16'd1,     0, STAT_OK,       48'd0,    48'd0},
        // Write zone meets the erase zone: log full, nothing changes.
        '{KIND_WRITE, 16'h5555,  1, STAT_FULL,     48'd0,    48'd0},
        '{KIND_ERASE, 16'hFFFF,  1, STAT_OK,       48'd0,    48'd0},
        '{KIND_SCAN,  16'hAAAA,  1, STAT_NOTFOUND, 48'd0,    48'd0},
        '{KIND_WRITE, 16'hAAAA,  0, STAT_OK,       48'd0,    48'd0}
    };

    initial
    begin
        int items, pick;
        logic [1:0] kind;
        reset_model();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            offer_operation(directed[i].kind, directed[i].id, directed[i].known,
                            directed[i].status, directed[i].location,
                            directed[i].zone_base);

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            wait_for_results();
            load_phase(p);
            idle_on = (p % 3 != 2);
            items = (p == 2 || p == 4) ? 180 : 240;
            for (int k = 0; k < items; k++)
            begin
                if (p == 5 && k == 40)
                    receiver_hold = 400;
                if (p == 6 && k == 60)
                    wait_for_results();
                pick = $urandom_range(0, 99);
                kind = (pick < 40) ? KIND_WRITE : (pick < 65) ? KIND_READ :
                       (pick < 85) ? KIND_ERASE : KIND_SCAN;
                offer_operation(kind, pick_bucket(kind == KIND_SCAN), 0,
                                STAT_OK, '0, '0);
            end
        end

        wait_for_results();
        if (error_count == 0)
            $display("zoned_log_bucket_mapper regression: pass");
        else
            $display("zoned_log_bucket_mapper regression: fail");
        $finish;
    end

endmodule
